// ===== rtl/core/usbe_pkg.sv =====
// Shared types, request codes and the descriptor ROM image for the EP0
// standard request engine. No dependencies.
package usbe_pkg;

  localparam int MAX_PACKET_DEF = 64;

  // Device events carried in the input tuser
  typedef enum logic [1:0] {
    EV_BUS_RESET = 2'd0,
    EV_SETUP     = 2'd1,
    EV_IN_DONE   = 2'd2,
    EV_OUT_DONE  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    DEV_POWERED    = 2'd0,
    DEV_DEFAULT    = 2'd1,
    DEV_ADDRESSED  = 2'd2,
    DEV_CONFIGURED = 2'd3
  } dev_state_e;

  // What one event answers with
  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_STALL = 2'd1,
    REPLY_ZLP   = 2'd2,
    REPLY_DATA  = 2'd3
  } reply_e;

  // Engine sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_READ,
    ST_PUT
  } fsm_e;

  localparam logic [1:0] TYPE_STANDARD  = 2'd0;
  localparam logic [4:0] RCPT_DEVICE    = 5'd0;
  localparam logic [3:0] EP_CONTROL     = 4'd0;

  localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;
  localparam logic [7:0] DESC_HID    = 8'h21;
  localparam logic [7:0] DESC_REPORT = 8'h22;

  localparam int ROM_DEPTH = 132;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  // Base and length of each reply inside the ROM image
  localparam logic [ROM_AW-1:0] BASE_DEV  = ROM_AW'(0);
  localparam logic [ROM_AW-1:0] BASE_CFG  = ROM_AW'(18);
  localparam logic [ROM_AW-1:0] BASE_HID  = ROM_AW'(36);
  localparam logic [ROM_AW-1:0] BASE_RPT  = ROM_AW'(52);
  localparam logic [ROM_AW-1:0] BASE_STR0 = ROM_AW'(115);
  localparam logic [ROM_AW-1:0] BASE_STRN = ROM_AW'(119);
  localparam logic [ROM_AW-1:0] BASE_ONE  = ROM_AW'(129);
  localparam logic [ROM_AW-1:0] BASE_TWOZ = ROM_AW'(130);
  // Offset of bMaxPacketSize0 in the device descriptor
  localparam logic [ROM_AW-1:0] ADDR_MPS  = ROM_AW'(7);

  localparam logic [6:0] LEN_DEV  = 7'd18;
  localparam logic [6:0] LEN_CFG  = 7'd34;
  localparam logic [6:0] LEN_HID  = 7'd9;
  localparam logic [6:0] LEN_RPT  = 7'd63;
  localparam logic [6:0] LEN_STR0 = 7'd4;
  localparam logic [6:0] LEN_STRN = 7'd10;
  localparam logic [6:0] LEN_ONE  = 7'd1;
  localparam logic [6:0] LEN_TWOZ = 7'd2;

  localparam logic [7:0] DESC_ROM [ROM_DEPTH] = '{
    // device descriptor (byte 7 patched with the packet size)
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hD8,
    8'h04, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
    // configuration, interface, HID and endpoint descriptors
    8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
    8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h01,
    // report descriptor
    8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07,
    8'h19, 8'hE0, 8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01,
    8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01,
    8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h05, 8'h75, 8'h01,
    8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
    8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01, 8'h95, 8'h06,
    8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07,
    8'h19, 8'h00, 8'h29, 8'h65, 8'h81, 8'h00, 8'hC0,
    // language string, name string
    8'h04, 8'h03, 8'h09, 8'h04,
    8'h0A, 8'h03, 8'h44, 8'h00, 8'h65, 8'h00, 8'h6D, 8'h00, 8'h30, 8'h00,
    // configuration value, status word
    8'h01, 8'h00, 8'h00
  };

  // Decoded setup request
  typedef struct packed {
    reply_e            kind;
    logic [ROM_AW-1:0] base;
    logic [6:0]        len;
    logic              set_addr;
    logic              set_cfg;
  } req_dec_t;

endpackage

// ===== rtl/core/usbe_desc_rom.sv =====
// Synchronous descriptor ROM with a registered read.
// Depends on usbe_pkg for the image and address width.
module usbe_desc_rom #(
  parameter int MaxPacket = usbe_pkg::MAX_PACKET_DEF
) (
  input  logic                       clk_i,
  input  logic [usbe_pkg::ROM_AW-1:0] addr_i,
  output logic [7:0]                 data_o
);

  logic [7:0] data_q;

  // Patch bMaxPacketSize0 on the way out
  always_ff @(posedge clk_i) begin
    if (addr_i == usbe_pkg::ADDR_MPS) begin
      data_q <= 8'(MaxPacket);
    end else begin
      data_q <= usbe_pkg::DESC_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/usbe_req_decode.sv =====
// Setup request decoder: picks the reply and the ROM slice to send.
// Depends on usbe_pkg.
module usbe_req_decode #(
  parameter int MaxPacket = usbe_pkg::MAX_PACKET_DEF
) (
  input  logic [4:0]         recipient_i,
  input  logic [1:0]         request_kind_i,
  input  logic [7:0]         request_code_i,
  input  logic [15:0]        request_value_i,
  output usbe_pkg::req_dec_t dec_o
);

  localparam logic [6:0] MaxLen = 7'(MaxPacket);

  logic [7:0] desc_type;
  logic [7:0] desc_index;

  assign desc_type  = request_value_i[15:8];
  assign desc_index = request_value_i[7:0];

  always_comb begin
    dec_o = '{kind: usbe_pkg::REPLY_STALL, base: '0, len: '0,
              set_addr: 1'b0, set_cfg: 1'b0};
    if (request_kind_i == usbe_pkg::TYPE_STANDARD) begin
      case (request_code_i)
        usbe_pkg::REQ_GET_CONFIGURATION: begin
          dec_o.kind = usbe_pkg::REPLY_DATA;
          dec_o.base = usbe_pkg::BASE_ONE;
          dec_o.len  = usbe_pkg::LEN_ONE;
        end
        usbe_pkg::REQ_GET_STATUS: begin
          if (recipient_i == usbe_pkg::RCPT_DEVICE) begin
            dec_o.kind = usbe_pkg::REPLY_DATA;
            dec_o.base = usbe_pkg::BASE_TWOZ;
            dec_o.len  = usbe_pkg::LEN_TWOZ;
          end
        end
        usbe_pkg::REQ_SET_ADDRESS: begin
          dec_o.kind     = usbe_pkg::REPLY_ZLP;
          dec_o.set_addr = 1'b1;
        end
        usbe_pkg::REQ_SET_CONFIGURATION: begin
          dec_o.kind    = usbe_pkg::REPLY_ZLP;
          dec_o.set_cfg = 1'b1;
        end
        usbe_pkg::REQ_GET_DESCRIPTOR: begin
          dec_o.kind = usbe_pkg::REPLY_DATA;
          if (desc_type == usbe_pkg::DESC_DEVICE) begin
            dec_o.base = usbe_pkg::BASE_DEV;
            dec_o.len  = usbe_pkg::LEN_DEV;
          end else if (desc_type == usbe_pkg::DESC_CONFIG && desc_index == 8'd0) begin
            dec_o.base = usbe_pkg::BASE_CFG;
            dec_o.len  = usbe_pkg::LEN_CFG;
          end else if (desc_type == usbe_pkg::DESC_STRING && desc_index == 8'd0) begin
            dec_o.base = usbe_pkg::BASE_STR0;
            dec_o.len  = usbe_pkg::LEN_STR0;
          end else if (desc_type == usbe_pkg::DESC_STRING &&
                       (desc_index == 8'd1 || desc_index == 8'd2)) begin
            dec_o.base = usbe_pkg::BASE_STRN;
            dec_o.len  = usbe_pkg::LEN_STRN;
          end else if (desc_type == usbe_pkg::DESC_REPORT && desc_index == 8'd0) begin
            dec_o.base = usbe_pkg::BASE_RPT;
            dec_o.len  = usbe_pkg::LEN_RPT;
          end else if (desc_type == usbe_pkg::DESC_HID && desc_index == 8'd0) begin
            dec_o.base = usbe_pkg::BASE_HID;
            dec_o.len  = usbe_pkg::LEN_HID;
          end else begin
            dec_o.kind = usbe_pkg::REPLY_STALL;
          end
          // single packet only: cut long descriptors
          if (dec_o.len > MaxLen) begin
            dec_o.len = MaxLen;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/usb_ep0_standard_request_engine.sv =====
// EP0 standard request engine: device state, address and IN toggle,
// with data replies streamed from a synchronous descriptor ROM.
// Flow: an accepted request goes to ST_REPLY, which loads the reply, or for data
// to ST_READ (ROM read) and then ST_PUT (output load) for each reply byte in turn;
//   ST_REPLY and ST_PUT wait for a free output, and no new request is taken until the last load.
// Reset (rst_ni low, asynchronous): state powered, address 0, nothing pending.
module usb_ep0_standard_request_engine #(
  parameter int MaxPacket = usbe_pkg::MAX_PACKET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] endpoint, [8:4] recipient, [10:9] request_kind, [11] direction,
  // [19:12] request_code, [35:20] request_value, [39:36] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [14:8] packet_length, [16:15] device_state,
  // [23:17] device_address
  output logic [23:0] m_axis_tdata_o,
  // [0] stall_res, [1] in_armed, [2] data_toggle
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int AW = usbe_pkg::ROM_AW;

  // request fields
  logic [3:0]        endpoint;
  logic [4:0]        recipient;
  logic [1:0]        request_kind;
  logic [7:0]        request_code;
  logic [15:0]       request_value;
  usbe_pkg::event_e  mode;

  assign endpoint      = s_axis_tdata_i[3:0];
  assign recipient     = s_axis_tdata_i[8:4];
  assign request_kind  = s_axis_tdata_i[10:9];
  assign request_code  = s_axis_tdata_i[19:12];
  assign request_value = s_axis_tdata_i[35:20];
  assign mode          = usbe_pkg::event_e'(s_axis_tuser_i);

  usbe_pkg::fsm_e       fsm_q, fsm_d;
  usbe_pkg::dev_state_e dev_state_q, dev_state_d;
  logic [6:0]           dev_addr_q, dev_addr_d;
  logic                 addr_pend_q, addr_pend_d;
  logic [6:0]           pend_addr_q, pend_addr_d;
  logic                 toggle_q, toggle_d;
  usbe_pkg::reply_e     kind_q, kind_d;
  logic [AW-1:0]        base_q, base_d;
  logic [6:0]           len_q, len_d;
  logic [6:0]           idx_q, idx_d;

  logic                 out_valid_q, out_valid_d;
  logic [23:0]          out_data_q, out_data_d;
  logic [2:0]           out_user_q, out_user_d;
  logic                 out_last_q, out_last_d;

  usbe_pkg::req_dec_t   dec;
  logic [7:0]           rom_data;
  logic [AW-1:0]        rom_addr;

  usbe_req_decode #(
    .MaxPacket(MaxPacket)
  ) u_decode (
    .recipient_i    (recipient),
    .request_kind_i (request_kind),
    .request_code_i (request_code),
    .request_value_i(request_value),
    .dec_o          (dec)
  );

  // address is held steady while a byte waits for the output register
  assign rom_addr = base_q + AW'(idx_q);

  usbe_desc_rom #(
    .MaxPacket(MaxPacket)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= usbe_pkg::ST_IDLE;
      dev_state_q <= usbe_pkg::DEV_POWERED;
      dev_addr_q  <= '0;
      addr_pend_q <= 1'b0;
      pend_addr_q <= '0;
      toggle_q    <= 1'b0;
      kind_q      <= usbe_pkg::REPLY_NONE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      dev_state_q <= dev_state_d;
      dev_addr_q  <= dev_addr_d;
      addr_pend_q <= addr_pend_d;
      pend_addr_q <= pend_addr_d;
      toggle_q    <= toggle_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    len_q      <= len_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    logic       out_free;
    logic       load;
    logic       armed;
    logic       is_last;
    logic [7:0] byte_out;
    logic [6:0] len_out;

    fsm_d       = fsm_q;
    dev_state_d = dev_state_q;
    dev_addr_d  = dev_addr_q;
    addr_pend_d = addr_pend_q;
    pend_addr_d = pend_addr_q;
    toggle_d    = toggle_q;
    kind_d      = kind_q;
    base_d      = base_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;

    out_free        = !out_valid_q || m_axis_tready_i;
    load            = 1'b0;
    is_last         = 1'b1;
    byte_out        = 8'd0;
    s_axis_tready_o = (fsm_q == usbe_pkg::ST_IDLE);

    case (fsm_q)
      usbe_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          // apply the event to the device state now; results report it after
          kind_d = usbe_pkg::REPLY_NONE;
          idx_d  = '0;
          len_d  = '0;
          base_d = '0;
          fsm_d  = usbe_pkg::ST_REPLY;
          case (mode)
            usbe_pkg::EV_BUS_RESET: begin
              dev_addr_d  = '0;
              dev_state_d = usbe_pkg::DEV_DEFAULT;
              addr_pend_d = 1'b0;
              toggle_d    = 1'b0;
            end
            usbe_pkg::EV_SETUP: begin
              kind_d   = dec.kind;
              base_d   = dec.base;
              len_d    = dec.len;
              // setup clears the toggle; an armed reply then goes as DATA1
              toggle_d = dec.kind inside {usbe_pkg::REPLY_ZLP, usbe_pkg::REPLY_DATA};
              if (dec.set_addr) begin
                addr_pend_d = 1'b1;
                pend_addr_d = request_value[6:0];
              end
              if (dec.set_cfg) begin
                dev_state_d = (request_value == 16'd0) ? usbe_pkg::DEV_ADDRESSED
                                                       : usbe_pkg::DEV_CONFIGURED;
              end
              if (dec.kind == usbe_pkg::REPLY_DATA) begin
                fsm_d = usbe_pkg::ST_READ;
              end
            end
            usbe_pkg::EV_IN_DONE: begin
              if (endpoint == usbe_pkg::EP_CONTROL && addr_pend_q) begin
                addr_pend_d = 1'b0;
                dev_addr_d  = pend_addr_q;
                dev_state_d = (pend_addr_q == 7'd0) ? usbe_pkg::DEV_DEFAULT
                                                    : usbe_pkg::DEV_ADDRESSED;
              end
            end
            usbe_pkg::EV_OUT_DONE: begin
              if (endpoint == usbe_pkg::EP_CONTROL) begin
                kind_d   = usbe_pkg::REPLY_ZLP;
                toggle_d = !toggle_q;
              end
            end
            default: ;
          endcase
        end
      end
      usbe_pkg::ST_REPLY: begin
        if (out_free) begin
          load  = 1'b1;
          fsm_d = usbe_pkg::ST_IDLE;
        end
      end
      usbe_pkg::ST_READ: begin
        fsm_d = usbe_pkg::ST_PUT;
      end
      usbe_pkg::ST_PUT: begin
        byte_out = rom_data;
        is_last  = (idx_q + 7'd1 == len_q);
        if (out_free) begin
          load  = 1'b1;
          idx_d = idx_q + 7'd1;
          fsm_d = is_last ? usbe_pkg::ST_IDLE : usbe_pkg::ST_READ;
        end
      end
      default: fsm_d = usbe_pkg::ST_IDLE;
    endcase

    armed   = kind_q inside {usbe_pkg::REPLY_ZLP, usbe_pkg::REPLY_DATA};
    len_out = (kind_q == usbe_pkg::REPLY_DATA) ? len_q : 7'd0;

    // hold the output until taken, drop valid once it is
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {dev_addr_q, dev_state_q, len_out, byte_out};
      out_user_d  = {armed && toggle_q, armed, kind_q == usbe_pkg::REPLY_STALL};
      out_last_d  = is_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== tb/ep0_reply_tracker_pkg.sv =====
`timescale 1ns / 100ps
// Reply tracker for the EP0 standard request engine: request and reply records,
// a private copy of the descriptor bytes and the expected-reply store.
// Depends on usbe_pkg for the event, state and request code names.
package ep0_reply_tracker_pkg;

  import usbe_pkg::*;

  localparam int PKT_MAX = MAX_PACKET_DEF;

  typedef struct packed {
    event_e      mode;
    logic [3:0]  endpoint;
    logic [4:0]  recipient;
    logic [1:0]  kind;
    logic        dir;
    logic [7:0]  code;
    logic [15:0] value;
  } ep0_req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] pkt_len;
    logic       fin;
    logic       stall;
    logic       armed;
    logic       toggle;
    logic [1:0] state;
    logic [6:0] address;
  } ep0_reply_t;

  // Offsets of each reply in the byte image below
  localparam int OFS_DEV  = 0;
  localparam int OFS_CFG  = 18;
  localparam int OFS_HID  = 36;
  localparam int OFS_RPT  = 52;
  localparam int OFS_STR0 = 115;
  localparam int OFS_STRN = 119;
  localparam int OFS_ONE  = 129;
  localparam int OFS_TWOZ = 130;
  localparam int MPS_BYTE = 7;

  localparam logic [7:0] REPLY_BYTES [132] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hD8,
    8'h04, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
    8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
    8'h09, 8'h21, 8'h00, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h01,
    8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07,
    8'h19, 8'hE0, 8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01,
    8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01,
    8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h05, 8'h75, 8'h01,
    8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
    8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01, 8'h95, 8'h06,
    8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07,
    8'h19, 8'h00, 8'h29, 8'h65, 8'h81, 8'h00, 8'hC0,
    8'h04, 8'h03, 8'h09, 8'h04,
    8'h0A, 8'h03, 8'h44, 8'h00, 8'h65, 8'h00, 8'h6D, 8'h00, 8'h30, 8'h00,
    8'h01, 8'h00, 8'h00
  };

  class ep0_reply_tracker;
    dev_state_e  state;
    logic [6:0]  address;
    logic        addr_pending;
    logic [6:0]  pending_addr;
    logic        in_toggle;
    ep0_reply_t  reply_q[$];
    int unsigned errors;

    function new();
      state        = DEV_POWERED;
      address      = '0;
      addr_pending = 1'b0;
      pending_addr = '0;
      in_toggle    = 1'b0;
      errors       = 0;
    endfunction

    // State and address go out as they stand after the event
    function void push_reply(logic [7:0] b, logic [6:0] n, logic fin, logic stall,
                             logic armed, logic tog);
      ep0_reply_t r;
      r.data_byte = b;
      r.pkt_len   = n;
      r.fin       = fin;
      r.stall     = stall;
      r.armed     = armed;
      r.toggle    = tog;
      r.state     = state;
      r.address   = address;
      reply_q.push_back(r);
    endfunction

    function void stall_ep0();
      in_toggle = 1'b0;
      push_reply('0, '0, 1'b1, 1'b1, 1'b0, 1'b0);
    endfunction

    // Arm one IN packet: flip the toggle, then one reply per byte, or a ZLP
    function void arm_packet(int ofs, int len, bit patch_mps);
      logic [7:0] b;
      if (len > PKT_MAX) len = PKT_MAX;
      in_toggle = ~in_toggle;
      if (len == 0) begin
        push_reply('0, '0, 1'b1, 1'b0, 1'b1, in_toggle);
      end else begin
        for (int i = 0; i < len; i++) begin
          b = (patch_mps && i == MPS_BYTE) ? 8'(PKT_MAX) : REPLY_BYTES[ofs + i];
          push_reply(b, 7'(len), i == len - 1, 1'b0, 1'b1, in_toggle);
        end
      end
    endfunction

    function void serve_descriptor(logic [15:0] value);
      logic [7:0] dtype;
      logic [7:0] idx;
      dtype = value[15:8];
      idx   = value[7:0];
      if (dtype == DESC_DEVICE) arm_packet(OFS_DEV, 18, 1'b1);
      else if (dtype == DESC_CONFIG && idx == 0) arm_packet(OFS_CFG, 34, 1'b0);
      else if (dtype == DESC_STRING && idx == 0) arm_packet(OFS_STR0, 4, 1'b0);
      else if (dtype == DESC_STRING && (idx == 1 || idx == 2))
        arm_packet(OFS_STRN, 10, 1'b0);
      else if (dtype == DESC_REPORT && idx == 0) arm_packet(OFS_RPT, 63, 1'b0);
      else if (dtype == DESC_HID && idx == 0) arm_packet(OFS_HID, 9, 1'b0);
      else stall_ep0();
    endfunction

    function void serve_setup(ep0_req_t q);
      in_toggle = 1'b0;
      if (q.kind != TYPE_STANDARD) begin
        stall_ep0();
        return;
      end
      case (q.code)
        REQ_GET_CONFIGURATION: arm_packet(OFS_ONE, 1, 1'b0);
        REQ_GET_DESCRIPTOR:    serve_descriptor(q.value);
        REQ_GET_STATUS: begin
          if (q.recipient != RCPT_DEVICE) stall_ep0();
          else arm_packet(OFS_TWOZ, 2, 1'b0);
        end
        REQ_SET_ADDRESS: begin
          addr_pending = 1'b1;
          pending_addr = q.value[6:0];
          arm_packet(0, 0, 1'b0);
        end
        REQ_SET_CONFIGURATION: begin
          state = (q.value == 0) ? DEV_ADDRESSED : DEV_CONFIGURED;
          arm_packet(0, 0, 1'b0);
        end
        default: stall_ep0();
      endcase
    endfunction

    // Note one accepted request and queue the replies that it causes
    function void note_request(ep0_req_t q);
      case (q.mode)
        EV_BUS_RESET: begin
          address      = '0;
          state        = DEV_DEFAULT;
          addr_pending = 1'b0;
          in_toggle    = 1'b0;
          push_reply('0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        EV_SETUP: serve_setup(q);
        EV_IN_DONE: begin
          if (q.endpoint == EP_CONTROL && addr_pending) begin
            addr_pending = 1'b0;
            address      = pending_addr;
            state        = (address == 0) ? DEV_DEFAULT : DEV_ADDRESSED;
          end
          push_reply('0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          if (q.endpoint == EP_CONTROL) arm_packet(0, 0, 1'b0);
          else push_reply('0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted reply with the oldest expectation
    function void check_reply(logic [23:0] data, logic [2:0] user, logic fin);
      ep0_reply_t want;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: reply with nothing expected, expected none, actual data 0x%0h",
                 $time, data);
        return;
      end
      want = reply_q.pop_front();
      check_field("data_byte", want.data_byte, data[7:0]);
      check_field("packet_length", want.pkt_len, data[14:8]);
      check_field("device_state", want.state, data[16:15]);
      check_field("device_address", want.address, data[23:17]);
      check_field("stall", want.stall, user[0]);
      check_field("in_armed", want.armed, user[1]);
      check_field("data_toggle", want.toggle, user[2]);
      check_field("last", want.fin, fin);
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the EP0 standard request engine: drives device events,
// predicts every reply byte with ep0_reply_tracker_pkg and checks the output stream.
// Depends on usbe_pkg and ep0_reply_tracker_pkg.
module tb;

  import usbe_pkg::*;
  import ep0_reply_tracker_pkg::*;

  // Values outside every decoded set, for the stall paths
  localparam logic [7:0] REQ_UNKNOWN  = 8'hFF;
  localparam logic [7:0] DESC_UNKNOWN = 8'hFF;
  localparam logic [1:0] TYPE_VENDOR  = 2'd3;
  localparam logic [4:0] RCPT_OTHER   = 5'd31;
  localparam logic [3:0] EP_HIGHEST   = 4'd15;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        req_valid   = 1'b0;
  logic        req_ready;
  logic [39:0] req_data    = '0;
  logic [1:0]  req_mode    = '0;
  logic        reply_valid;
  logic        reply_ready = 1'b0;
  logic [23:0] reply_data;
  logic [2:0]  reply_user;
  logic        reply_last;

  ep0_reply_tracker tracker;
  int unsigned      idle_pct  = 23;
  int unsigned      hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  usb_ep0_standard_request_engine #(
    .MaxPacket(PKT_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i (req_data),
    .s_axis_tuser_i (req_mode),
    .m_axis_tvalid_o(reply_valid),
    .m_axis_tready_i(reply_ready),
    .m_axis_tdata_o (reply_data),
    .m_axis_tuser_o (reply_user),
    .m_axis_tlast_o (reply_last)
  );

  // Build one request; the direction bit is unused by the block, so randomise it
  function automatic ep0_req_t mk_req(event_e ev, logic [3:0] ep, logic [4:0] rcpt,
                                      logic [1:0] kind, logic [7:0] code,
                                      logic [15:0] value);
    ep0_req_t q;
    q.mode      = ev;
    q.endpoint  = ep;
    q.recipient = rcpt;
    q.kind      = kind;
    q.dir       = 1'($urandom);
    q.code      = code;
    q.value     = value;
    return q;
  endfunction

  // Mostly well-formed standard requests, with a share of pure noise
  function automatic ep0_req_t random_request();
    ep0_req_t    q;
    int unsigned roll;
    logic [7:0]  dtype;
    roll = $urandom_range(99);
    q = mk_req(EV_SETUP, 4'($urandom),
               ($urandom_range(7) == 0) ? 5'($urandom) : RCPT_DEVICE,
               TYPE_STANDARD, REQ_GET_STATUS, 16'($urandom));
    if (roll < 12) begin
      q.mode      = event_e'($urandom_range(3));
      q.recipient = 5'($urandom);
      q.kind      = 2'($urandom);
      q.code      = 8'($urandom);
    end else if (roll < 15) begin
      q.mode = EV_BUS_RESET;
    end else if (roll < 40) begin
      q.mode     = (roll < 30) ? EV_IN_DONE : EV_OUT_DONE;
      q.endpoint = ($urandom_range(3) == 0) ? 4'($urandom) : EP_CONTROL;
    end else begin
      case ($urandom_range(4))
        0: q.code = REQ_GET_STATUS;
        1: q.code = REQ_SET_ADDRESS;
        2: q.code = REQ_GET_CONFIGURATION;
        3: begin
          q.code  = REQ_SET_CONFIGURATION;
          q.value = $urandom_range(1) ? 16'd0 : 16'($urandom);
        end
        default: begin
          case ($urandom_range(6))
            0: dtype = DESC_DEVICE;
            1: dtype = DESC_CONFIG;
            2: dtype = DESC_STRING;
            3: dtype = DESC_HID;
            4: dtype = DESC_REPORT;
            5: dtype = DESC_STRING;
            default: dtype = 8'($urandom);
          endcase
          q.code  = REQ_GET_DESCRIPTOR;
          q.value = {dtype, ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3))};
        end
      endcase
    end
    return q;
  endfunction

  // Offer one request after a random gap; hold valid high between back-to-back
  // requests so that it is never dropped and raised in the same step
  task automatic send_request(ep0_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_mode  <= q.mode;
    req_data  <= {4'b0, q.value, q.code, q.dir, q.kind, q.recipient, q.endpoint};
    do @(posedge clk_i); while (!req_ready);
    tracker.note_request(q);
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is asked for
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        reply_ready <= 1'b0;
      end else begin
        reply_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Check every reply taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && reply_valid && reply_ready)
      tracker.check_reply(reply_data, reply_user, reply_last);
  end

  initial begin
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every event, every request and each stall path
    send_request(mk_req(EV_IN_DONE, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD, '0, '0));
    send_request(mk_req(EV_BUS_RESET, EP_HIGHEST, RCPT_OTHER, TYPE_VENDOR,
                        REQ_UNKNOWN, 16'hFFFF));
    send_request(mk_req(EV_SETUP, EP_HIGHEST, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'hFF}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'd0}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'd1}));
    for (int i = 0; i < 4; i++)
      send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                          REQ_GET_DESCRIPTOR, {DESC_STRING, 8'(i)}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_REPORT, 8'd0}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_HID, 8'd0}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_DESCRIPTOR, {DESC_UNKNOWN, 8'd0}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_OTHER, TYPE_STANDARD,
                        REQ_GET_CONFIGURATION, 16'hFFFF));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_GET_STATUS, '0));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_OTHER, TYPE_STANDARD,
                        REQ_GET_STATUS, '0));
    // Address is kept to seven bits and only taken on the next EP0 IN done
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_OTHER, TYPE_STANDARD,
                        REQ_SET_ADDRESS, 16'hFFFF));
    send_request(mk_req(EV_IN_DONE, EP_HIGHEST, RCPT_DEVICE, TYPE_STANDARD, '0, '0));
    send_request(mk_req(EV_IN_DONE, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD, '0, '0));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_SET_CONFIGURATION, 16'hFFFF));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_SET_CONFIGURATION, '0));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_VENDOR,
                        REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'd0}));
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_UNKNOWN, '0));
    send_request(mk_req(EV_OUT_DONE, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD, '0, '0));
    send_request(mk_req(EV_OUT_DONE, EP_HIGHEST, RCPT_DEVICE, TYPE_STANDARD, '0, '0));
    // Pending address zero drops the device back to default
    send_request(mk_req(EV_SETUP, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD,
                        REQ_SET_ADDRESS, '0));
    send_request(mk_req(EV_IN_DONE, EP_CONTROL, RCPT_DEVICE, TYPE_STANDARD, '0, '0));

    // Random part: a long receiver hold-off early on, and a stretch with no idling
    for (int n = 0; n < 280; n++) begin
      if (n == 60) hold_left = 400;
      idle_pct = (n >= 150 && n < 200) ? 0 : 23;
      send_request(random_request());
    end
    req_valid <= 1'b0;

    // Drain the expected replies, then allow a quiet tail for strays
    while (tracker.reply_q.size() != 0) @(posedge clk_i);
    repeat (2 * PKT_MAX + 8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.reply_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/usbe_pkg.sv
rtl/core/usbe_desc_rom.sv
rtl/core/usbe_req_decode.sv
rtl/core/usb_ep0_standard_request_engine.sv
tb/ep0_reply_tracker_pkg.sv
tb/tb.sv
